/* sv/pba_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page bitmap allocator package
// Shared sizes, operation codes, controller states and the word edit bundle.
// ---------------------------------------------------------------------------
package pba_pkg;

   localparam int BITMAP_WORDS = 1024;
   localparam int WORD_BITS    = 32;
   localparam int BIT_W        = 5;
   localparam int WORD_AW      = $clog2(BITMAP_WORDS);
   localparam int TOTAL_PAGES  = BITMAP_WORDS * WORD_BITS;
   localparam int PAGE_SHIFT   = 12;
   localparam int LARGE_PAGES  = 512;

   localparam int OP_W      = 3;
   localparam int ADDR_W    = 27;
   localparam int SIZE_W    = 28;
   localparam int COUNT_W   = 16;
   localparam int COUNT_MAX = (TOTAL_PAGES > 65535) ? 65535 : TOTAL_PAGES;

   // page number taken from an address, page span taken from a size
   localparam int PAGE_IN_W = ADDR_W - PAGE_SHIFT;
   localparam int SPAN_W    = SIZE_W - PAGE_SHIFT + 1;
   localparam int PAGE_CW   = $clog2(TOTAL_PAGES + 1);
   // holds first page + span, and any page number up to TOTAL_PAGES
   localparam int END_W     = (PAGE_CW > SPAN_W) ? PAGE_CW + 1 : SPAN_W + 1;
   localparam int DELTA_W   = BIT_W + 1;

   localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC      = 3'd0,
      OP_FREE_PAGE  = 3'd1,
      OP_FREE_LARGE = 3'd2,
      OP_MARK_USED  = 3'd3,
      OP_MARK_FREE  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RUN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                 alloc;
      logic                 set;
      logic [WORD_BITS-1:0] mask;
   } edit_ctrl_type;

endpackage

/* sv/pba_word_edit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap word edit
// Finds the lowest free bit of a word and forms the written-back word.
// ---------------------------------------------------------------------------
module pba_word_edit (
   input  pba_pkg::edit_ctrl_type          ctrl,
   input  logic [pba_pkg::WORD_BITS-1:0]   word_rd,
   output logic [pba_pkg::WORD_BITS-1:0]   word_wr,
   output logic                            word_full,
   output logic [pba_pkg::BIT_W-1:0]       first_free
);
   import pba_pkg::*;

   logic [WORD_BITS-1:0] alloc_bit;

   always_comb begin
      first_free = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word_rd[i]) begin
            first_free = BIT_W'(i);
         end
      end
   end

   assign word_full = (word_rd == FULL_WORD);
   assign alloc_bit = WORD_BITS'(1) << first_free;

   always_comb begin
      if (ctrl.alloc) begin
         word_wr = word_rd | alloc_bit;
      end else if (ctrl.set) begin
         word_wr = word_rd | ctrl.mask;
      end else begin
         word_wr = word_rd & ~ctrl.mask;
      end
   end

endmodule

/* sv/page_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page bitmap allocator
// One bit per 4 KiB page in a 32-bit word memory. First-fit allocate from
// word 1, free of one page or a large run, mark of a byte region used/free,
// and a saturating used-page counter.
// ---------------------------------------------------------------------------
//
//   channel | ports                                      | beat
//   --------+--------------------------------------------+------------------
//   req     | req_valid/req_ready, operation/address/size | one operation
//   rsp     | rsp_valid/rsp_ready, block_address/oom/used | one result
//
// Flow: allocate reads words in turn from word 1 until one with a free page
//   (at most BITMAP_WORDS-1 words). Region ops read and write back each
//   bitmap word the page span touches (none for an empty span); unknown
//   codes go straight to the result beat.
//   One memory read port and one write port set the pace: one word/cycle.
// Reset: the bitmap is swept to all ones with req_ready low.
// Stalls: one operation at a time; req_ready comes back once the result beat
//   is taken.
//
module page_bitmap_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pba_pkg::OP_W-1:0]      req_operation,
   input  logic [pba_pkg::ADDR_W-1:0]    req_address,
   input  logic [pba_pkg::SIZE_W-1:0]    req_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pba_pkg::ADDR_W-1:0]    rsp_block_address,
   output logic                          rsp_out_of_memory,
   output logic [pba_pkg::COUNT_W-1:0]   rsp_used_pages
);
   import pba_pkg::*;

   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(BITMAP_WORDS - 1);

   // bitmap memory, registered read
   logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic                 wr_en;
   logic [WORD_AW-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   state_type state_ff, state_in;

   logic [WORD_AW-1:0]   clr_ff, clr_in;        // reset sweep pointer
   logic [WORD_AW-1:0]   scan_ff, scan_in;      // allocate read pointer
   logic                 scan_done_ff, scan_done_in;
   logic [END_W-1:0]     cur_ff, cur_in;        // next page of a run
   logic [END_W-1:0]     end_ff, end_in;        // run end, exclusive, clamped
   logic                 set_ff, set_in;

   // data stage: word whose read data shows up this cycle
   logic                 p_vld_ff, p_vld_in;
   logic [WORD_AW-1:0]   p_addr_ff, p_addr_in;
   logic [WORD_BITS-1:0] p_mask_ff, p_mask_in;
   logic [DELTA_W-1:0]   p_delta_ff, p_delta_in;

   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    blk_ff, blk_in;
   logic                 oom_ff, oom_in;

   // request decode
   op_type               req_op;
   logic [END_W-1:0]     first_page;
   logic [SIZE_W:0]      size_round;
   logic [SPAN_W-1:0]    span;
   logic [END_W-1:0]     end_raw;
   logic [END_W-1:0]     end_clamp;

   // run word mask
   logic                 run_more;
   logic [END_W-1:0]     next_base;
   logic [BIT_W-1:0]     run_lo;
   logic [BIT_W-1:0]     run_hi;
   logic [WORD_BITS-1:0] run_mask;
   logic [DELTA_W-1:0]   run_delta;

   // counter step
   logic [DELTA_W-1:0]   step;
   logic [COUNT_W:0]     cnt_sum;
   logic [COUNT_W-1:0]   cnt_up;
   logic [COUNT_W-1:0]   cnt_down;

   edit_ctrl_type        edit_ctrl;
   logic [WORD_BITS-1:0] edit_word;
   logic                 edit_full;
   logic [BIT_W-1:0]     edit_bit;

   pba_word_edit u_edit (
      .ctrl       (edit_ctrl),
      .word_rd    (rd_data_ff),
      .word_wr    (edit_word),
      .word_full  (edit_full),
      .first_free (edit_bit)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bitmap_mem[rd_addr];
      end
   end

   // --- request decode: page number and clamped run end --------------------
   assign req_op     = op_type'(req_operation);
   assign first_page = END_W'(req_address[ADDR_W-1:PAGE_SHIFT]);
   assign size_round = (SIZE_W+1)'(req_size) + (SIZE_W+1)'((1 << PAGE_SHIFT) - 1);

   always_comb begin
      case (req_op)
         OP_FREE_PAGE:  span = SPAN_W'(1);
         OP_FREE_LARGE: span = SPAN_W'(LARGE_PAGES);
         default:       span = size_round[SIZE_W:PAGE_SHIFT];
      endcase
   end

   assign end_raw   = first_page + END_W'(span);
   assign end_clamp = (end_raw > END_W'(TOTAL_PAGES)) ? END_W'(TOTAL_PAGES) : end_raw;

   // --- run: bits of the current word that lie in [cur, end) ---------------
   assign run_more  = (cur_ff < end_ff);
   assign next_base = {cur_ff[END_W-1:BIT_W] + 1'b1, BIT_W'(0)};
   assign run_lo    = cur_ff[BIT_W-1:0];
   assign run_hi    = (end_ff >= next_base) ? BIT_W'(WORD_BITS - 1)
                                            : end_ff[BIT_W-1:0] - 1'b1;
   assign run_mask  = (FULL_WORD << run_lo) & (FULL_WORD >> (BIT_W'(WORD_BITS - 1) - run_hi));
   assign run_delta = DELTA_W'(run_hi) - DELTA_W'(run_lo) + 1'b1;

   // --- saturating counter, one step per written word ----------------------
   assign step     = (state_ff == ST_SCAN) ? DELTA_W'(1) : p_delta_ff;
   assign cnt_sum  = (COUNT_W+1)'(cnt_ff) + (COUNT_W+1)'(step);
   assign cnt_up   = (cnt_sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : cnt_sum[COUNT_W-1:0];
   assign cnt_down = (cnt_ff < COUNT_W'(step)) ? '0 : cnt_ff - COUNT_W'(step);

   assign edit_ctrl.alloc = (state_ff == ST_SCAN);
   assign edit_ctrl.set   = set_ff;
   assign edit_ctrl.mask  = p_mask_ff;

   // --- controller ---------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      scan_done_in = scan_done_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      set_in       = set_ff;
      p_vld_in     = 1'b0;
      p_addr_in    = p_addr_ff;
      p_mask_in    = p_mask_ff;
      p_delta_in   = p_delta_ff;
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      oom_in       = oom_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = FULL_WORD;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               blk_in       = '0;
               oom_in       = 1'b0;
               scan_in      = WORD_AW'(1);
               scan_done_in = 1'b0;
               cur_in       = first_page;
               end_in       = end_clamp;
               set_in       = (req_op == OP_MARK_USED);
               case (req_op)
                  OP_ALLOC:      state_in = ST_SCAN;
                  OP_FREE_PAGE,
                  OP_FREE_LARGE,
                  OP_MARK_USED,
                  OP_MARK_FREE:  state_in = ST_RUN;
                  default:       state_in = ST_RESP;
               endcase
            end
         end

         ST_SCAN: begin
            // one word read per cycle; reads past a hit are dropped
            if (!scan_done_ff) begin
               rd_en     = 1'b1;
               rd_addr   = scan_ff;
               p_vld_in  = 1'b1;
               p_addr_in = scan_ff;
               scan_in   = scan_ff + 1'b1;
               if (scan_ff == LAST_WORD) begin
                  scan_done_in = 1'b1;
               end
            end
            if (p_vld_ff) begin
               if (!edit_full) begin
                  wr_en    = 1'b1;
                  wr_addr  = p_addr_ff;
                  wr_data  = edit_word;
                  cnt_in   = cnt_up;
                  blk_in   = ADDR_W'({p_addr_ff, edit_bit, PAGE_SHIFT'(0)});
                  state_in = ST_RESP;
               end else if (p_addr_ff == LAST_WORD) begin
                  oom_in   = 1'b1;
                  state_in = ST_RESP;
               end
            end
         end

         ST_RUN: begin
            // read word k while writing back word k-1
            if (run_more) begin
               rd_en      = 1'b1;
               rd_addr    = cur_ff[WORD_AW+BIT_W-1:BIT_W];
               p_vld_in   = 1'b1;
               p_addr_in  = cur_ff[WORD_AW+BIT_W-1:BIT_W];
               p_mask_in  = run_mask;
               p_delta_in = run_delta;
               cur_in     = next_base;
            end
            if (p_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = p_addr_ff;
               wr_data = edit_word;
               cnt_in  = set_ff ? cnt_up : cnt_down;
            end
            if (!run_more && !p_vld_ff) begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         p_vld_ff <= 1'b0;
         cnt_ff   <= COUNT_W'(COUNT_MAX);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         p_vld_ff <= p_vld_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      scan_done_ff <= scan_done_in;
      cur_ff       <= cur_in;
      end_ff       <= end_in;
      set_ff       <= set_in;
      p_addr_ff    <= p_addr_in;
      p_mask_ff    <= p_mask_in;
      p_delta_ff   <= p_delta_in;
      blk_ff       <= blk_in;
      oom_ff       <= oom_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_block_address = blk_ff;
   assign rsp_out_of_memory = oom_ff;
   assign rsp_used_pages    = cnt_ff;

endmodule

/* sim/pba_result_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page bitmap allocator result checker
// Keeps its own page bitmap and used-page count, works out one result per
// accepted request beat and compares each result beat, in order, field by field.
// ---------------------------------------------------------------------------
module pba_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [pba_pkg::OP_W-1:0]     req_operation,
   input  logic [pba_pkg::ADDR_W-1:0]   req_address,
   input  logic [pba_pkg::SIZE_W-1:0]   req_size,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [pba_pkg::ADDR_W-1:0]   rsp_block_address,
   input  logic                         rsp_out_of_memory,
   input  logic [pba_pkg::COUNT_W-1:0]  rsp_used_pages,
   output int unsigned                  mismatches,
   output int unsigned                  results_waiting
);
   import pba_pkg::*;

   localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

   typedef struct packed {
      logic [ADDR_W-1:0]  block_address;
      logic               out_of_memory;
      logic [COUNT_W-1:0] used_pages;
   } result_type;

   logic [WORD_BITS-1:0] page_map [BITMAP_WORDS];
   int unsigned          pages_in_use;
   result_type           awaited_results [$];

   // counter moves on every in-range page, whatever its old bit
   function automatic void set_page(int unsigned page, bit used);
      if (page >= TOTAL_PAGES) return;
      page_map[page / WORD_BITS][page % WORD_BITS] = used;
      if (used) begin
         if (pages_in_use < COUNT_MAX) pages_in_use++;
      end else if (pages_in_use > 0) begin
         pages_in_use--;
      end
   endfunction

   function automatic void set_run(int unsigned first, int unsigned count, bit used);
      for (int unsigned k = 0; k < count; k++) begin
         if (first + k >= TOTAL_PAGES) break;
         set_page(first + k, used);
      end
   endfunction

   function automatic result_type apply_operation(logic [OP_W-1:0] op,
         logic [ADDR_W-1:0] address, logic [SIZE_W-1:0] size);
      result_type  res;
      int unsigned first;
      int unsigned span;
      bit          found;
      res   = '0;
      found = 1'b0;
      first = address >> PAGE_SHIFT;
      span  = (32'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
      case (op)
         OP_ALLOC: begin
            // first fit from word 1; word 0 is never handed out
            for (int w = 1; w < BITMAP_WORDS && !found; w++) begin
               if (page_map[w] != FULL_WORD) begin
                  for (int b = 0; b < WORD_BITS && !found; b++) begin
                     if (!page_map[w][b]) begin
                        set_page(w * WORD_BITS + b, 1'b1);
                        res.block_address = ADDR_W'((w * WORD_BITS + b) << PAGE_SHIFT);
                        found = 1'b1;
                     end
                  end
               end
            end
            res.out_of_memory = !found;
         end
         OP_FREE_PAGE:  set_page(first, 1'b0);
         OP_FREE_LARGE: set_run(first, LARGE_PAGES, 1'b0);
         OP_MARK_USED:  set_run(first, span, 1'b1);
         OP_MARK_FREE:  set_run(first, span, 1'b0);
         default: ;
      endcase
      res.used_pages = COUNT_W'(pages_in_use);
      return res;
   endfunction

   always @(posedge clock) begin
      result_type  want;
      int unsigned errs;
      errs = 0;
      if (reset) begin
         foreach (page_map[w]) page_map[w] = FULL_WORD;
         pages_in_use = COUNT_MAX;
         awaited_results.delete();
         results_waiting <= 0;
      end else begin
         // result side first: it always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result beat with no request outstanding: block_address %h",
                  rsp_block_address);
               errs++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_block_address !== want.block_address) begin
                  $error("block_address: expected %h, got %h",
                     want.block_address, rsp_block_address);
                  errs++;
               end
               if (rsp_out_of_memory !== want.out_of_memory) begin
                  $error("out_of_memory: expected %b, got %b",
                     want.out_of_memory, rsp_out_of_memory);
                  errs++;
               end
               if (rsp_used_pages !== want.used_pages) begin
                  $error("used_pages: expected %0d, got %0d",
                     want.used_pages, rsp_used_pages);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(apply_operation(req_operation, req_address, req_size));
         results_waiting <= awaited_results.size();
         mismatches      <= mismatches + errs;
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page bitmap allocator testbench
// Directed corner beats, then a long random mix of allocate, free and region
// marks with random idling on both channels; the checker judges every result.
// ---------------------------------------------------------------------------
module tb;
   import pba_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
   localparam int MAP_BYTES    = TOTAL_PAGES * PAGE_BYTES;
   localparam int LARGE_BYTES  = LARGE_PAGES * PAGE_BYTES;
   localparam int RANDOM_BEATS = 1280;
   localparam int DRAIN_EVERY  = 250;
   // slowest ops are a full scan, a full-map mark and the reset sweep
   localparam int STALL_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 1100;
   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [OP_W-1:0]    req_operation = '0;
   logic [ADDR_W-1:0]  req_address   = '0;
   logic [SIZE_W-1:0]  req_size      = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [ADDR_W-1:0]  rsp_block_address;
   logic               rsp_out_of_memory;
   logic [COUNT_W-1:0] rsp_used_pages;
   int unsigned        mismatches;
   int unsigned        results_waiting;
   int unsigned        quiet_cycles = 0;
   bit                 calm = 1'b0;     // stretch with no idling on either side

   always #HALF_PERIOD clock = ~clock;

   page_bitmap_allocator_unit DUT (.*);

   pba_result_checker result_check (.*);

   // idle cycles before each beat, both channels
   function automatic int unsigned idle_cycles();
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // mostly low pages so that allocate scans stay short; the rest anywhere
   function automatic logic [ADDR_W-1:0] pick_address();
      if ($urandom_range(0, 9) < 7)
         return ADDR_W'($urandom_range(0, 2047) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
      return ADDR_W'($urandom());
   endfunction

   // small regions mostly, some empty, a few of any width (full map and past it)
   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 93) return SIZE_W'($urandom_range(1, 16 * PAGE_BYTES));
      return SIZE_W'($urandom());
   endfunction

   // valid drops only when a gap is drawn, so back-to-back beats keep it high
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] address,
         input logic [SIZE_W-1:0] size);
      int unsigned gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_address   <= address;
      req_size      <= size;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every result is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   // result side: random stall per beat, then ready held until a beat lands
   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // watchdog: no beat on either channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("page_bitmap_allocator_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned     roll;
      logic [OP_W-1:0] op;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // after reset every page is used: allocate runs out of memory
      send_beat(OP_ALLOC, '0, '0);
      // ignored codes, all fields at their top
      for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
         send_beat(OP_W'(c), '1, '1);
      // page 0 freed but never handed out by allocate
      send_beat(OP_FREE_PAGE, '0, '0);
      // last page, top address bits set
      send_beat(OP_FREE_PAGE, '1, '0);
      // only the last page is free: highest block address
      send_beat(OP_ALLOC, '0, '0);
      send_beat(OP_ALLOC, '0, '0);
      // empty region touches nothing
      send_beat(OP_MARK_FREE, ADDR_W'(40 * PAGE_BYTES), '0);
      // unaligned base, one byte over a page: rounds up to two pages
      send_beat(OP_MARK_FREE, ADDR_W'(40 * PAGE_BYTES + 123), SIZE_W'(PAGE_BYTES + 1));
      send_beat(OP_ALLOC, '0, '0);
      // large run and region both running off the end of the map
      send_beat(OP_FREE_LARGE, ADDR_W'((TOTAL_PAGES - 100) * PAGE_BYTES), '0);
      send_beat(OP_MARK_USED, ADDR_W'((TOTAL_PAGES - 1) * PAGE_BYTES), SIZE_W'(3 * PAGE_BYTES));
      // large run over word 0 and up: allocate lands on page 32
      send_beat(OP_FREE_LARGE, '0, '0);
      send_beat(OP_ALLOC, '0, '0);
      // widest size frees everything; counter bottoms out and stays at zero
      send_beat(OP_MARK_FREE, '0, '1);
      send_beat(OP_FREE_PAGE, ADDR_W'(77 * PAGE_BYTES), '0);
      send_beat(OP_ALLOC, '0, '0);
      // whole map used; counter tops out and stays there
      send_beat(OP_MARK_USED, '0, SIZE_W'(MAP_BYTES));
      send_beat(OP_MARK_USED, ADDR_W'(5 * PAGE_BYTES), SIZE_W'(PAGE_BYTES));
      send_beat(OP_ALLOC, '0, '0);
      // open up 2048 low pages for the random mix
      send_beat(OP_MARK_FREE, ADDR_W'(32 * PAGE_BYTES), SIZE_W'(4 * LARGE_BYTES));
      wait_for_results();

      // --- random mix ---
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_for_results();
         roll = $urandom_range(0, 99);
         if (roll < 32) op = OP_ALLOC;
         else if (roll < 57) op = OP_FREE_PAGE;
         else if (roll < 62) op = OP_FREE_LARGE;
         else if (roll < 78) op = OP_MARK_USED;
         else if (roll < 95) op = OP_MARK_FREE;
         else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         send_beat(op, pick_address(), pick_size());
      end

      // drain, then give a stray beat time to show up
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("page_bitmap_allocator_unit test passed");
      else
         $display("page_bitmap_allocator_unit test failed");
      $finish;
   end

endmodule

/* files.f */
sv/pba_pkg.sv
sv/pba_word_edit.sv
sv/page_bitmap_allocator_unit.sv
sim/pba_result_checker.sv
sim/tb.sv
